// ----- rtl/core/pks_pkg.sv -----
// Shared codes, state encoding and controller/datapath interface types.
package pks_pkg;

    // Operation codes on func
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_SEARCH = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    // Result codes on status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_ORDER     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Reserved key value
    localparam logic [31:0] KEY_INVALID = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS,
        S_PG_ISSUE,
        S_PG_WAIT,
        S_REC_SETUP,
        S_REC_ISSUE,
        S_REC_WAIT,
        S_HIT,
        S_RESP
    } pks_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // latch a new item
        logic ins;        // perform insert
        logic pg_issue;   // first page table probe
        logic pg_step;    // evaluate page probe, maybe issue next
        logic rec_setup;  // set up record search in chosen page
        logic rec_issue;  // first record probe
        logic rec_step;   // evaluate record probe, maybe issue next
        logic hit;        // act on the matched record
        logic out_load;   // move result into the output register
    } pks_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic op_insert;
        logic op_lookup;
        logic store_empty;
        logic pg_hit;
        logic pg_end;
        logic rec_hit;
        logic rec_end;
    } pks_stat_t;

endpackage

// ----- rtl/core/pks_ram.sv -----
// Generic single-port RAM with registered read data.
module pks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic                                          wr_en,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read; read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/pks_ctrl.sv -----
// Sequencer for insert, page search, record search and result hand-off.
module pks_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pks_pkg::pks_stat_t  stat,
    output pks_pkg::pks_cmd_t   cmd
);
    import pks_pkg::*;

    pks_state_t state_reg;
    pks_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.op_insert)
                begin
                    state_next = S_INS;
                end
                else if (stat.op_lookup && !stat.store_empty)
                begin
                    state_next = S_PG_ISSUE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_INS:       state_next = S_RESP;
            S_PG_ISSUE:  state_next = S_PG_WAIT;
            S_PG_WAIT:
            begin
                if (stat.pg_hit)
                begin
                    state_next = S_REC_SETUP;
                end
                else if (stat.pg_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_REC_SETUP: state_next = S_REC_ISSUE;
            S_REC_ISSUE: state_next = S_REC_WAIT;
            S_REC_WAIT:
            begin
                if (stat.rec_hit)
                begin
                    state_next = S_HIT;
                end
                else if (stat.rec_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_HIT:       state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_DECODE:    ;
            S_INS:       cmd.ins = 1'b1;
            S_PG_ISSUE:  cmd.pg_issue = 1'b1;
            S_PG_WAIT:   cmd.pg_step = 1'b1;
            S_REC_SETUP: cmd.rec_setup = 1'b1;
            S_REC_ISSUE: cmd.rec_issue = 1'b1;
            S_REC_WAIT:  cmd.rec_step = 1'b1;
            S_HIT:       cmd.hit = 1'b1;
            S_RESP:      cmd.out_load = out_free;
            default:     ;
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/pks_dpath.sv -----
// Datapath: record and page memories, search bounds, insert bookkeeping, result.
module pks_dpath #(
    parameter int RECORDS_PER_PAGE = 256,
    parameter int PAGE_COUNT       = 16,
    parameter int PAYLOAD_BITS     = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pks_pkg::pks_cmd_t  cmd,
    output pks_pkg::pks_stat_t stat,
    input  logic [1:0]         func,
    input  logic [31:0]        key,
    input  logic [31:0]        data_in,
    output logic [1:0]         status,
    output logic [31:0]        data_out
);
    import pks_pkg::*;

    localparam int PLW       = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int PG_AW     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PC_W      = $clog2(PAGE_COUNT + 1);
    localparam int RC_W      = $clog2(RECORDS_PER_PAGE + 1);
    localparam int RI_W      = $clog2(RECORDS_PER_PAGE);
    localparam int REC_DEPTH = PAGE_COUNT * RECORDS_PER_PAGE;
    localparam int RA_W      = $clog2(REC_DEPTH);
    localparam int PG_WW     = 64 + RC_W;
    localparam int REC_WW    = 1 + PLW + 32;

    // Latched item
    logic [1:0]       func_reg;
    logic [31:0]      key_reg;
    logic [PLW-1:0]   din_reg;

    // Last page bookkeeping
    logic [PC_W-1:0]  pages_reg, pages_next;
    logic [RC_W-1:0]  last_fill_reg, last_fill_next;
    logic [31:0]      last_first_reg, last_first_next;
    logic [31:0]      last_key_reg, last_key_next;

    // Search bounds (exclusive upper bounds)
    logic [PC_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [PG_AW-1:0] pmid_reg, pmid_next;
    logic [PG_AW-1:0] pg_reg, pg_next;
    logic [RC_W-1:0]  fill_reg, fill_next;
    logic [RA_W-1:0]  base_reg, base_next;
    logic [RC_W-1:0]  rlo_reg, rlo_next, rhi_reg, rhi_next;
    logic [RI_W-1:0]  rmid_reg, rmid_next;

    // Working and output result
    logic [1:0]       res_st_reg, res_st_next;
    logic [31:0]      res_data_reg, res_data_next;
    logic [1:0]       status_reg;
    logic [31:0]      data_out_reg;

    // Memory ports
    logic [PG_AW-1:0]  pg_addr;
    logic              pg_we, pg_re;
    logic [PG_WW-1:0]  pg_wdata, pg_rd;
    logic [RA_W-1:0]   rec_addr;
    logic              rec_we, rec_re;
    logic [REC_WW-1:0] rec_wdata, rec_rd;

    // Decoded fields of read words
    logic [31:0]      pg_first, pg_last;
    logic [RC_W-1:0]  pg_fill;
    logic             rec_present;
    logic [PLW-1:0]   rec_payload;
    logic [31:0]      rec_key;

    // Insert decisions
    logic             need_new, ins_full, ins_order, ins_ok;
    logic [PG_AW-1:0] ins_pg;
    logic [RI_W-1:0]  ins_idx;
    logic [RA_W-1:0]  ins_addr;
    logic [RC_W-1:0]  ins_fill;
    logic [31:0]      ins_first;

    // Page probe arithmetic
    logic [PC_W:0]    psum_cur, psum_nxt;
    logic [PG_AW-1:0] pmid_cur, pmid_nxt;
    logic             pg_below, pg_above, pg_hit, pg_end;
    logic [PC_W-1:0]  plo_n, phi_n;

    // Record probe arithmetic
    logic [RC_W:0]    rsum_cur, rsum_nxt;
    logic [RI_W-1:0]  rmid_cur, rmid_nxt;
    logic             rec_below, rec_above, rec_hit, rec_end;
    logic [RC_W-1:0]  rlo_n, rhi_n;
    logic             del_write;

    assign pg_first    = pg_rd[PG_WW-1 -: 32];
    assign pg_last     = pg_rd[RC_W +: 32];
    assign pg_fill     = pg_rd[RC_W-1:0];
    assign rec_present = rec_rd[REC_WW-1];
    assign rec_payload = rec_rd[32 +: PLW];
    assign rec_key     = rec_rd[31:0];

    // Insert checks: full before order
    assign need_new  = (pages_reg == '0) ||
                       (last_fill_reg == RC_W'(RECORDS_PER_PAGE));
    assign ins_full  = need_new && (pages_reg == PC_W'(PAGE_COUNT));
    assign ins_order = (key_reg == KEY_INVALID) ||
                       ((pages_reg != '0) && (key_reg <= last_key_reg));
    assign ins_ok    = !ins_full && !ins_order;
    assign ins_pg    = need_new ? PG_AW'(pages_reg) : PG_AW'(pages_reg - PC_W'(1));
    assign ins_idx   = need_new ? '0 : RI_W'(last_fill_reg);
    assign ins_addr  = RA_W'(ins_pg) * RA_W'(RECORDS_PER_PAGE) + RA_W'(ins_idx);
    assign ins_fill  = need_new ? RC_W'(1) : last_fill_reg + RC_W'(1);
    assign ins_first = need_new ? key_reg : last_first_reg;

    // Page probe: midpoint of current and narrowed ranges
    assign psum_cur  = {1'b0, lo_reg} + {1'b0, hi_reg} - (PC_W+1)'(1);
    assign pmid_cur  = PG_AW'(psum_cur >> 1);
    assign pg_below  = key_reg < pg_first;
    assign pg_above  = key_reg > pg_last;
    assign pg_hit    = !pg_below && !pg_above;
    assign plo_n     = pg_above ? PC_W'(pmid_reg) + PC_W'(1) : lo_reg;
    assign phi_n     = pg_below ? PC_W'(pmid_reg) : hi_reg;
    assign pg_end    = !pg_hit && (plo_n >= phi_n);
    assign psum_nxt  = {1'b0, plo_n} + {1'b0, phi_n} - (PC_W+1)'(1);
    assign pmid_nxt  = PG_AW'(psum_nxt >> 1);

    // Record probe: same scheme inside the chosen page
    assign rsum_cur  = {1'b0, rlo_reg} + {1'b0, rhi_reg} - (RC_W+1)'(1);
    assign rmid_cur  = RI_W'(rsum_cur >> 1);
    assign rec_below = key_reg < rec_key;
    assign rec_above = key_reg > rec_key;
    assign rec_hit   = !rec_below && !rec_above;
    assign rlo_n     = rec_above ? RC_W'(rmid_reg) + RC_W'(1) : rlo_reg;
    assign rhi_n     = rec_below ? RC_W'(rmid_reg) : rhi_reg;
    assign rec_end   = !rec_hit && (rlo_n >= rhi_n);
    assign rsum_nxt  = {1'b0, rlo_n} + {1'b0, rhi_n} - (RC_W+1)'(1);
    assign rmid_nxt  = RI_W'(rsum_nxt >> 1);

    assign del_write = cmd.hit && rec_present && (func_reg == FN_DELETE);

    // Page table port
    always_comb
    begin
        pg_we    = cmd.ins && ins_ok;
        pg_re    = cmd.pg_issue || (cmd.pg_step && !pg_hit && !pg_end);
        pg_wdata = {ins_first, key_reg, ins_fill};
        if (cmd.ins)
        begin
            pg_addr = ins_pg;
        end
        else if (cmd.pg_step)
        begin
            pg_addr = pmid_nxt;
        end
        else
        begin
            pg_addr = pmid_cur;
        end
    end

    // Record store port
    always_comb
    begin
        rec_we = (cmd.ins && ins_ok) || del_write;
        rec_re = cmd.rec_issue || (cmd.rec_step && !rec_hit && !rec_end);
        if (cmd.ins)
        begin
            rec_addr  = ins_addr;
            rec_wdata = {1'b1, din_reg, key_reg};
        end
        else
        begin
            rec_wdata = {1'b0, rec_payload, rec_key};
            if (cmd.hit)
            begin
                rec_addr = base_reg + RA_W'(rmid_reg);
            end
            else if (cmd.rec_step)
            begin
                rec_addr = base_reg + RA_W'(rmid_nxt);
            end
            else
            begin
                rec_addr = base_reg + RA_W'(rmid_cur);
            end
        end
    end

    pks_ram #(
        .WIDTH (PG_WW),
        .DEPTH (PAGE_COUNT)
    ) u_page_ram (
        .clk     (clk),
        .addr    (pg_addr),
        .wr_en   (pg_we),
        .wr_data (pg_wdata),
        .rd_en   (pg_re),
        .rd_data (pg_rd)
    );

    pks_ram #(
        .WIDTH (REC_WW),
        .DEPTH (REC_DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .addr    (rec_addr),
        .wr_en   (rec_we),
        .wr_data (rec_wdata),
        .rd_en   (rec_re),
        .rd_data (rec_rd)
    );

    // Next values of the bookkeeping and search registers
    always_comb
    begin
        pages_next      = pages_reg;
        last_fill_next  = last_fill_reg;
        last_first_next = last_first_reg;
        last_key_next   = last_key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        pmid_next       = pmid_reg;
        pg_next         = pg_reg;
        fill_next       = fill_reg;
        base_next       = base_reg;
        rlo_next        = rlo_reg;
        rhi_next        = rhi_reg;
        rmid_next       = rmid_reg;
        res_st_next     = res_st_reg;
        res_data_next   = res_data_reg;

        if (cmd.load)
        begin
            lo_next       = '0;
            hi_next       = pages_reg;
            res_st_next   = ST_NOT_FOUND;
            res_data_next = '0;
        end

        // Append and update the last page
        if (cmd.ins)
        begin
            if (ins_full)
            begin
                res_st_next = ST_FULL;
            end
            else if (ins_order)
            begin
                res_st_next = ST_ORDER;
            end
            else
            begin
                res_st_next     = ST_OK;
                pages_next      = need_new ? pages_reg + PC_W'(1) : pages_reg;
                last_fill_next  = ins_fill;
                last_first_next = ins_first;
                last_key_next   = key_reg;
            end
        end

        if (cmd.pg_issue)
        begin
            pmid_next = pmid_cur;
        end

        // Narrow the page range or take the page
        if (cmd.pg_step)
        begin
            if (pg_hit)
            begin
                pg_next   = pmid_reg;
                fill_next = pg_fill;
            end
            else
            begin
                lo_next   = plo_n;
                hi_next   = phi_n;
                pmid_next = pmid_nxt;
            end
        end

        if (cmd.rec_setup)
        begin
            base_next = RA_W'(pg_reg) * RA_W'(RECORDS_PER_PAGE);
            rlo_next  = '0;
            rhi_next  = fill_reg;
        end

        if (cmd.rec_issue)
        begin
            rmid_next = rmid_cur;
        end

        // Narrow the record range
        if (cmd.rec_step && !rec_hit)
        begin
            rlo_next  = rlo_n;
            rhi_next  = rhi_n;
            rmid_next = rmid_nxt;
        end

        // Act on the matched record
        if (cmd.hit && rec_present)
        begin
            res_st_next = ST_OK;
            if (func_reg == FN_SEARCH)
            begin
                res_data_next = 32'(rec_payload);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pages_reg     <= '0;
            last_fill_reg <= '0;
        end
        else
        begin
            pages_reg     <= pages_next;
            last_fill_reg <= last_fill_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg  <= key;
            din_reg  <= data_in[PLW-1:0];
        end
        last_first_reg <= last_first_next;
        last_key_reg   <= last_key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pmid_reg       <= pmid_next;
        pg_reg         <= pg_next;
        fill_reg       <= fill_next;
        base_reg       <= base_next;
        rlo_reg        <= rlo_next;
        rhi_reg        <= rhi_next;
        rmid_reg       <= rmid_next;
        res_st_reg     <= res_st_next;
        res_data_reg   <= res_data_next;
        if (cmd.out_load)
        begin
            status_reg   <= res_st_reg;
            data_out_reg <= res_data_reg;
        end
    end

    always_comb
    begin
        stat.op_insert   = (func_reg == FN_INSERT);
        stat.op_lookup   = (func_reg == FN_SEARCH) || (func_reg == FN_DELETE);
        stat.store_empty = (pages_reg == '0);
        stat.pg_hit      = pg_hit;
        stat.pg_end      = pg_end;
        stat.rec_hit     = rec_hit;
        stat.rec_end     = rec_end;
    end

    assign status   = status_reg;
    assign data_out = data_out_reg;

endmodule

// ----- rtl/core/paged_sorted_key_store.sv -----
// Top level of the paged sorted key store: controller plus datapath.
//
// Append-only store of key/payload records in PAGE_COUNT pages of
// RECORDS_PER_PAGE records. Inserts need strictly increasing keys and land
// in the last page; search and delete binary-search the page table by first
// and last key, then the records of the chosen page. One item is worked at a
// time and gives exactly one result. A search or delete makes at most
// clog2(pages in use) + 1 page probes and clog2(RECORDS_PER_PAGE) + 1 record
// probes; each probe is one read of the single-port page or record memory.
// A key that falls in no page answers without record probes, and a lookup on
// an empty store, or an unused func code, answers without any probe. The next
// item is accepted as soon as the previous result is in the output register,
// even if that result is still waiting. No clearing pass runs after reset.
module paged_sorted_key_store #(
    parameter int RECORDS_PER_PAGE = 256,
    parameter int PAGE_COUNT       = 16,
    parameter int PAYLOAD_BITS     = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] key,
    input  logic [31:0] data_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] data_out
);
    import pks_pkg::*;

    pks_cmd_t  cmd;
    pks_stat_t stat;

    pks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pks_dpath #(
        .RECORDS_PER_PAGE (RECORDS_PER_PAGE),
        .PAGE_COUNT       (PAGE_COUNT),
        .PAYLOAD_BITS     (PAYLOAD_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .func     (func),
        .key      (key),
        .data_in  (data_in),
        .status   (status),
        .data_out (data_out)
    );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the paged sorted key store.
module tb_top;
    import pks_pkg::*;

    localparam int RECORDS_PER_PAGE = 256;
    localparam int PAGE_COUNT       = 16;
    localparam int CAPACITY         = RECORDS_PER_PAGE * PAGE_COUNT;

    // func code with no operation behind it
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
    } store_result_t;

    // Mirror of the store contents; predicts and checks each result
    class paged_store_tracker;
        logic [31:0]   rec_key [CAPACITY];
        logic [31:0]   rec_payload [CAPACITY];
        bit            rec_live [CAPACITY];
        logic [31:0]   pg_first [PAGE_COUNT];
        logic [31:0]   pg_last [PAGE_COUNT];
        int            pg_fill [PAGE_COUNT];
        int            pages_open;
        store_result_t pending_results[$];
        int            errors;

        function new();
            pages_open = 0;
            errors = 0;
            foreach (pg_fill[i]) pg_fill[i] = 0;
        endfunction

        // Locate a key: page by first/last key, then record inside the page
        function int find_record(logic [31:0] k);
            int lo;
            int hi;
            int mid;
            int pg;
            int slot;
            lo = 0;
            hi = pages_open - 1;
            pg = -1;
            while (lo <= hi && pg < 0)
            begin
                mid = lo + (hi - lo) / 2;
                if (k < pg_first[mid])
                    hi = mid - 1;
                else if (k > pg_last[mid])
                    lo = mid + 1;
                else
                    pg = mid;
            end
            if (pg < 0)
                return -1;
            lo = 0;
            hi = pg_fill[pg] - 1;
            while (lo <= hi)
            begin
                mid = lo + (hi - lo) / 2;
                slot = pg * RECORDS_PER_PAGE + mid;
                if (k < rec_key[slot])
                    hi = mid - 1;
                else if (k > rec_key[slot])
                    lo = mid + 1;
                else
                    return slot;
            end
            return -1;
        endfunction

        // Append to the last page; full check comes before the order check
        function logic [1:0] append_record(logic [31:0] k, logic [31:0] d);
            bit need_page;
            int pg;
            int slot;
            need_page = (pages_open == 0) || (pg_fill[pages_open - 1] >= RECORDS_PER_PAGE);
            if (need_page && pages_open >= PAGE_COUNT)
                return ST_FULL;
            if (k == KEY_INVALID)
                return ST_ORDER;
            if (pages_open != 0 && k <= pg_last[pages_open - 1])
                return ST_ORDER;
            if (need_page)
            begin
                pages_open++;
                pg_fill[pages_open - 1] = 0;
            end
            pg = pages_open - 1;
            slot = pg * RECORDS_PER_PAGE + pg_fill[pg];
            rec_key[slot] = k;
            rec_payload[slot] = d;
            rec_live[slot] = 1'b1;
            if (pg_fill[pg] == 0)
                pg_first[pg] = k;
            pg_last[pg] = k;
            pg_fill[pg]++;
            return ST_OK;
        endfunction

        // Work out the result of an accepted item and queue it
        function void take_request(logic [1:0] op, logic [31:0] k, logic [31:0] d);
            store_result_t r;
            int slot;
            r.status = ST_NOT_FOUND;
            r.data = '0;
            if (op == FN_INSERT)
                r.status = append_record(k, d);
            else if (op == FN_SEARCH || op == FN_DELETE)
            begin
                slot = find_record(k);
                if (slot >= 0 && rec_live[slot])
                begin
                    r.status = ST_OK;
                    if (op == FN_SEARCH)
                        r.data = rec_payload[slot];
                    else
                        rec_live[slot] = 1'b0;
                end
            end
            pending_results.push_back(r);
        endfunction

        // Compare a returned result with the oldest prediction
        function void match_response(logic [1:0] st, logic [31:0] dout);
            store_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: status=%0d data_out=%h", st, dout);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, st);
                errors++;
            end
            if (dout !== want.data)
            begin
                $error("data_out: expected %h, actual %h", want.data, dout);
                errors++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [31:0] key = '0;
    logic [31:0] data_in = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [31:0] data_out;

    paged_store_tracker tracker;
    int          burst_left = 0;
    logic [31:0] stored_keys[$];
    logic [31:0] last_key = '0;
    int          stall_len = 0;
    logic [31:0] stall_bits = '1;

    paged_sorted_key_store #(
        .RECORDS_PER_PAGE(RECORDS_PER_PAGE),
        .PAGE_COUNT(PAGE_COUNT),
        .PAYLOAD_BITS(32)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .key(key),
        .data_in(data_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .data_out(data_out)
    );

    always #5 clk = ~clk;

    // Hold reset, then release it once
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Stall the result side on a rotating random pattern, sometimes not at all
    always @(negedge clk)
    begin
        if (stall_len == 0)
        begin
            stall_len = $urandom_range(8, 64);
            stall_bits = ($urandom_range(3) == 0) ? '1 : $urandom;
        end
        else
        begin
            stall_len--;
            stall_bits = {stall_bits[0], stall_bits[31:1]};
        end
        out_ready <= stall_bits[0];
    end

    // Check every result taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.match_response(status, data_out);
    end

    // Drive one item in bursts with random gaps; return once accepted
    task automatic send_item(input logic [1:0] op, input logic [31:0] k,
                             input logic [31:0] d);
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 10);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= op;
        key <= k;
        data_in <= d;
        burst_left--;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        tracker.take_request(op, k, d);
    endtask

    // Issue one random item; in-order inserts step the key by at most max_step
    task automatic random_op(input int unsigned ins_pct, input int unsigned max_step);
        int unsigned pick;
        int unsigned sel;
        int unsigned room;
        int unsigned reserve;
        int unsigned limit;
        logic [1:0]  op;
        logic [31:0] k;
        logic [31:0] d;
        pick = $urandom_range(99);
        sel = $urandom_range(19);
        d = ($urandom_range(7) != 0) ? $urandom : ($urandom_range(1) ? 32'h0 : '1);
        if (pick < ins_pct)
        begin
            op = FN_INSERT;
            if ($urandom_range(9) == 0)
            begin
                // reuse an old key or the reserved one
                k = (stored_keys.size() == 0 || sel == 0) ? KEY_INVALID
                    : stored_keys[$urandom_range(stored_keys.size() - 1)];
            end
            else if (stored_keys.size() >= CAPACITY)
            begin
                k = $urandom;
            end
            else
            begin
                // leave enough key space for the records still to come
                room = 32'hFFFF_FFFE - last_key;
                reserve = CAPACITY - 1 - stored_keys.size();
                limit = (room - reserve < max_step) ? room - reserve : max_step;
                if (limit == 0)
                    limit = 1;
                k = last_key + $urandom_range(1, limit);
                stored_keys.push_back(k);
                last_key = k;
            end
        end
        else if (pick < 96)
        begin
            op = ($urandom_range(2) == 0) ? FN_DELETE : FN_SEARCH;
            if (stored_keys.size() == 0 || sel >= 18)
                k = (sel == 19) ? KEY_INVALID : $urandom;
            else
            begin
                k = stored_keys[$urandom_range(stored_keys.size() - 1)];
                // near misses around stored keys and page edges
                if (sel >= 13)
                    k = sel[0] ? k + 32'd1 : k - 32'd1;
            end
        end
        else
        begin
            op = FN_UNUSED;
            k = $urandom;
        end
        send_item(op, k, d);
    endtask

    initial
    begin
        tracker = new();
        @(posedge rst_n);

        // Empty store, unused code, reserved key
        send_item(FN_SEARCH, 32'd5, 32'h1234_5678);
        send_item(FN_DELETE, 32'd0, 32'h0);
        send_item(FN_UNUSED, 32'd7, '1);
        send_item(FN_INSERT, KEY_INVALID, 32'h5555_5555);
        // First records, duplicates, extremes of payload
        send_item(FN_INSERT, 32'd0, '1);
        send_item(FN_INSERT, 32'd0, 32'h1);
        send_item(FN_INSERT, 32'd10, 32'h0);
        send_item(FN_SEARCH, 32'd0, 32'h0);
        send_item(FN_SEARCH, 32'd10, '1);
        send_item(FN_SEARCH, 32'd5, 32'h0);
        send_item(FN_SEARCH, KEY_INVALID, 32'h0);
        send_item(FN_DELETE, KEY_INVALID, 32'h0);
        // Delete, then lookups of the deleted record
        send_item(FN_DELETE, 32'd10, 32'h0);
        send_item(FN_SEARCH, 32'd10, 32'h0);
        send_item(FN_DELETE, 32'd10, 32'h0);
        send_item(FN_INSERT, 32'd5, 32'hDEAD_BEEF);
        send_item(FN_INSERT, 32'd10, 32'hDEAD_BEEF);
        send_item(FN_UNUSED, 32'd0, 32'h0);
        send_item(FN_INSERT, 32'd20, 32'hA5A5_5A5A);
        send_item(FN_SEARCH, 32'd20, 32'h0);
        stored_keys = '{32'd0, 32'd10, 32'd20};
        last_key = 32'd20;

        // Mixed traffic, insert-heavy enough to open a second page
        repeat (400) random_op(80, 32'h0010_0000);

        // Lookups on both sides of the first page boundary
        if (stored_keys.size() > RECORDS_PER_PAGE)
        begin
            send_item(FN_SEARCH, stored_keys[RECORDS_PER_PAGE], 32'h0);
            send_item(FN_SEARCH, stored_keys[RECORDS_PER_PAGE - 1] + 32'd1, 32'h0);
            send_item(FN_DELETE, stored_keys[RECORDS_PER_PAGE - 1], 32'h0);
            send_item(FN_SEARCH, stored_keys[RECORDS_PER_PAGE - 1], 32'h0);
        end

        // Lookups and deletes over the whole store
        repeat (220) random_op(10, 1);

        // Largest valid key, then nothing can follow it
        send_item(FN_INSERT, 32'hFFFF_FFFE, $urandom);
        send_item(FN_INSERT, KEY_INVALID, 32'h0);
        send_item(FN_INSERT, 32'd0, '1);
        send_item(FN_SEARCH, 32'hFFFF_FFFE, 32'h0);

        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- paged_sorted_key_store.f -----
rtl/core/pks_pkg.sv
rtl/core/pks_ram.sv
rtl/core/pks_ctrl.sv
rtl/core/pks_dpath.sv
rtl/core/paged_sorted_key_store.sv
dv/tb_top.sv
